// ===== rtl/core/charlieplex_led_bitplane_scanner_core_macros.svh =====
// Assertion macros for the checker file of the scanner core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CHARLIEPLEX_LED_BITPLANE_SCANNER_CORE_MACROS_SVH
`define CHARLIEPLEX_LED_BITPLANE_SCANNER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLBS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/clbs_pkg.sv =====
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared constants, codes and types of the charlieplexed LED scanner core.
// ----------------------------------------------------------------------------
package clbs_pkg;

	localparam int DEF_PLANES = 4;
	localparam int ROWS       = 10;
	localparam int FWD_ROWS   = 5;
	localparam int COLS       = 3;
	localparam int ROW_W      = 4;

	localparam logic [1:0] ACT_SET_ONE = 2'd0;
	localparam logic [1:0] ACT_SET_ALL = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;

	// Write request from the input stage to the column store.
	typedef struct packed {
		logic       set_one;
		logic       set_all;
		logic [4:0] led;
		logic [7:0] value;
	} wr_req_t;

	// One scan result.
	typedef struct packed {
		logic [7:0]       latch_byte;
		logic [7:0]       direction_mask;
		logic [ROW_W-1:0] row_index;
	} result_t;

endpackage

// ===== rtl/core/clbs_item_if.sv =====
// ----------------------------------------------------------------------------
// clbs_item_if
// Input channel: one set or scan-tick request per transaction.
// ----------------------------------------------------------------------------
interface clbs_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [4:0] led;
	logic [7:0] value;

	modport source (output valid, output action, output led, output value, input ready);
	modport sink   (input valid, input action, input led, input value, output ready);
endinterface

// ===== rtl/core/clbs_result_if.sv =====
// ----------------------------------------------------------------------------
// clbs_result_if
// Output channel: one latch/direction pair per scan tick.
// ----------------------------------------------------------------------------
interface clbs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] latch_byte;
	logic [7:0] direction_mask;
	logic [3:0] row_index;

	modport source (output valid, output latch_byte, output direction_mask,
		output row_index, input ready);
	modport sink   (input valid, input latch_byte, input direction_mask,
		input row_index, output ready);
endinterface

// ===== rtl/core/clbs_store.sv =====
// ----------------------------------------------------------------------------
// clbs_store
// Bit-plane column store: per logical row and column, one bit for each plane.
// Written by set-one and set-all requests, read one row at a time.
// ----------------------------------------------------------------------------
module clbs_store #(
	parameter int PLANES = clbs_pkg::DEF_PLANES
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  clbs_pkg::wr_req_t                           wr,
	input  logic [clbs_pkg::ROW_W-1:0]                  rd_row,
	output logic [clbs_pkg::COLS-1:0][PLANES-1:0]       rd_cols
);
	import clbs_pkg::*;

	logic [PLANES-1:0] mem_q [ROWS][COLS];
	logic [PLANES-1:0] bits;

	// The top bits of the brightness, plane p in bit p.
	assign bits = wr.value[7 -: PLANES];

	// Reverse-polarity rows hold inverted bits, so their reset state is all ones.
	// The LED index of row r, column c is 3r + c for both halves of the matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					mem_q[r][c] <= (r < FWD_ROWS) ? '0 : '1;
				end
			end
		end else begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					if (wr.set_all || (wr.set_one && (wr.led == 5'(r * COLS + c)))) begin
						mem_q[r][c] <= (r < FWD_ROWS) ? bits : ~bits;
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			rd_cols[c] = mem_q[rd_row][c];
		end
	end

endmodule

// ===== rtl/core/clbs_scan.sv =====
// ----------------------------------------------------------------------------
// clbs_scan
// Row counter and modulation sequence position, plane selection and the
// forming of the latch and direction bytes for the next scanned row.
// ----------------------------------------------------------------------------
module clbs_scan #(
	parameter int PLANES = clbs_pkg::DEF_PLANES
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        tick,
	output logic [clbs_pkg::ROW_W-1:0]                  rd_row,
	input  logic [clbs_pkg::COLS-1:0][PLANES-1:0]       rd_cols,
	output clbs_pkg::result_t                           res
);
	import clbs_pkg::*;

	localparam int PW      = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int SeqLast = (1 << PLANES) - 2;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_nxt;
	logic [PLANES-1:0] seq_q;
	logic [PLANES-1:0] seq_nxt;
	logic [PW-1:0]     plane;
	logic              reverse;
	logic [2:0]        phys;

	always_comb begin
		if (row_q == ROW_LAST) begin
			row_nxt = '0;
			seq_nxt = (seq_q == PLANES'(SeqLast)) ? '0 : seq_q + 1'b1;
		end else begin
			row_nxt = row_q + 1'b1;
			seq_nxt = seq_q;
		end
	end

	// Plane shown is PLANES-1 less the trailing ones of the position,
	// so plane p comes up 2^p times per sequence.
	always_comb begin
		int  ones;
		logic run;
		ones = 0;
		run  = 1'b1;
		for (int i = 0; i < PLANES - 1; i++) begin
			if (run && seq_nxt[i]) begin
				ones = ones + 1;
			end else begin
				run = 1'b0;
			end
		end
		plane = PW'(PLANES - 1 - ones);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			seq_q <= '0;
		end else if (tick) begin
			row_q <= row_nxt;
			seq_q <= seq_nxt;
		end
	end

	assign rd_row  = row_nxt;
	assign reverse = (row_nxt >= ROW_W'(FWD_ROWS));
	assign phys    = reverse ? 3'(row_nxt - ROW_W'(FWD_ROWS)) : 3'(row_nxt);

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			res.latch_byte[c] = rd_cols[c][plane];
		end
		res.latch_byte[7:3]     = reverse ? 5'h1f : 5'h00;
		res.direction_mask[2:0] = 3'b000;
		for (int k = 0; k < FWD_ROWS; k++) begin
			res.direction_mask[3 + k] = (phys != 3'(k));
		end
		res.row_index = row_nxt;
	end

endmodule

// ===== rtl/core/charlieplex_led_bitplane_scanner_core.sv =====
// ----------------------------------------------------------------------------
// charlieplex_led_bitplane_scanner_core
// Scanner for a 30-LED charlieplexed matrix with binary bit-plane modulation.
//
// The block takes one transaction per clock on the item channel, whether it
// sets one LED, sets all LEDs or is a scan tick. Each item passes through an
// input register and is finished from there: set requests write the column
// store and give no result, a scan tick advances the row and sequence counters
// and loads the result register, so a tick's latch and direction bytes pass
// through the input register and then the result register. The result
// register lets the next item in while a result waits; only a tick that meets
// a full, stalled result register holds the input register, and with it the
// item channel. There is no clearing pass: the store resets to all LEDs off.
// ----------------------------------------------------------------------------
module charlieplex_led_bitplane_scanner_core #(
	parameter int PLANES = clbs_pkg::DEF_PLANES
) (
	input  logic          clk,
	input  logic          arst_n,
	clbs_item_if.sink     item,
	clbs_result_if.source result
);
	import clbs_pkg::*;

	logic       v_s1;
	logic [1:0] act_s1;
	logic [4:0] led_s1;
	logic [7:0] val_s1;

	logic       tick_s1;
	logic       adv_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    res_nxt;
	wr_req_t    wr;

	logic [ROW_W-1:0]              rd_row;
	logic [COLS-1:0][PLANES-1:0]   rd_cols;

	assign tick_s1    = v_s1 && (act_s1 == ACT_TICK);
	assign adv_s1     = v_s1 && (!tick_s1 || !res_valid_q || result.ready);
	assign item.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			act_s1 <= item.action;
			led_s1 <= item.led;
			val_s1 <= item.value;
		end
	end

	always_comb begin
		wr.set_one = v_s1 && (act_s1 == ACT_SET_ONE);
		wr.set_all = v_s1 && (act_s1 == ACT_SET_ALL);
		wr.led     = led_s1;
		wr.value   = val_s1;
	end

	clbs_store #(.PLANES(PLANES)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_row  (rd_row),
		.rd_cols (rd_cols)
	);

	clbs_scan #(.PLANES(PLANES)) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_s1 && adv_s1),
		.rd_row  (rd_row),
		.rd_cols (rd_cols),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_s1 && adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_s1 && adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.latch_byte     = res_q.latch_byte;
	assign result.direction_mask = res_q.direction_mask;
	assign result.row_index      = res_q.row_index;

endmodule

// ===== rtl/core/clbs_checker.sv =====
// ----------------------------------------------------------------------------
// clbs_checker
// Port-level checks on the scanner core's result channel.
// ----------------------------------------------------------------------------
`include "charlieplex_led_bitplane_scanner_core_macros.svh"

module clbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] latch_byte,
	input logic [7:0] direction_mask,
	input logic [3:0] row_index
);

	// A stalled result keeps its contents.
	`CLBS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(latch_byte) && $stable(direction_mask) && $stable(row_index), "result changed while stalled")

	`CLBS_ASSERT_SAME(a_row_range, out_valid, row_index <= 4'd9, "row index out of range")

	// Row levels follow the polarity of the scanned row.
	`CLBS_ASSERT_SAME(a_row_levels, out_valid, (row_index >= 4'd5 && latch_byte[7:3] == 5'h1f) || (row_index < 4'd5 && latch_byte[7:3] == 5'h00), "row levels do not match polarity")

	// Exactly one physical row is driven and the columns are always driven.
	`CLBS_ASSERT_SAME(a_dir_shape, out_valid, $countones(direction_mask) == 4 && direction_mask[2:0] == 3'b000, "bad direction mask")

endmodule

bind charlieplex_led_bitplane_scanner_core clbs_checker u_clbs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.latch_byte     (result.latch_byte),
	.direction_mask (result.direction_mask),
	.row_index      (result.row_index)
);
